// ===== rtl/core/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite screen projection package
// Shared constants, register indexes, structures and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Per-item divider: numerator and divisor magnitudes.
    localparam int DIV_NW = 44;
    localparam int DIV_DW = 32;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_CAM_POS_X    = 3'd0;
    localparam logic [2:0] REG_CAM_POS_Y    = 3'd1;
    localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
    localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_VIEW_PLANE_X = 3'd4;
    localparam logic [2:0] REG_VIEW_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_SCREEN_W     = 3'd6;
    localparam logic [2:0] REG_SCREEN_H     = 3'd7;

    localparam logic signed [31:0] RST_DIR_X   = -32'sd65536;
    localparam logic signed [31:0] RST_PLANE_Y = 32'sd43254;
    localparam logic [11:0]        RST_WIDTH   = 12'd640;
    localparam logic [11:0]        RST_HEIGHT  = 12'd480;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
        logic [11:0]        width;
        logic [11:0]        height;
        logic signed [31:0] inv;
        logic               det_zero;
    } t_cam;

    typedef struct packed {
        logic [DIV_NW-1:0]  ncol;
        logic [DIV_NW-1:0]  nsize;
        logic [DIV_DW-1:0]  den;
        logic               cneg;
        logic signed [31:0] lat;
        logic signed [31:0] dep;
        logic               fault;
    } t_fr;

    typedef struct packed {
        logic signed [31:0] lateral;
        logic signed [31:0] depth;
        logic signed [15:0] screen_col;
        logic [15:0]        obj_size;
        logic [11:0]        top_row;
        logic [11:0]        bottom_row;
        logic [14:0]        left_col;
        logic signed [15:0] right_col;
        logic               in_front;
        logic               div_fault;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssp_cfg.sv =====
// ----------------------------------------------------------------------------
// Sprite projection configuration
// Register file behind the APB port, and a sequencer that forms the camera
// determinant and its inverse after reset and after every write.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_cfg #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ssp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output ssp_pkg::t_cam                   o_cam,
    output logic                            o_busy
);
    import ssp_pkg::*;

    localparam int NB = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(NB);

    typedef enum logic [2:0] {ST_IDLE, ST_MUL_A, ST_MUL_B, ST_DET, ST_DIV, ST_SAT} t_state;

    t_state             r_state, n_state;
    logic signed [31:0] r_pos_x, r_pos_y, r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [11:0]        r_width, r_height;
    logic signed [63:0] r_pa, r_pb;
    logic [31:0]        r_dabs;
    logic               r_dneg, r_det_zero;
    logic [31:0]        r_rem;
    logic [NB-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic signed [31:0] r_inv;

    logic               wr;
    logic [2:0]         idx;
    logic signed [65:0] diff, qs;
    logic signed [31:0] det;
    logic [32:0]        trial;
    logic               take;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    always_comb begin
        unique case (idx)
            REG_CAM_POS_X:    prdata = r_pos_x;
            REG_CAM_POS_Y:    prdata = r_pos_y;
            REG_VIEW_DIR_X:   prdata = r_dir_x;
            REG_VIEW_DIR_Y:   prdata = r_dir_y;
            REG_VIEW_PLANE_X: prdata = r_plane_x;
            REG_VIEW_PLANE_Y: prdata = r_plane_y;
            REG_SCREEN_W:     prdata = {20'd0, r_width};
            REG_SCREEN_H:     prdata = {20'd0, r_height};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= RST_DIR_X;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= RST_PLANE_Y;
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
        end else if (wr) begin
            unique case (idx)
                REG_CAM_POS_X:    r_pos_x   <= pwdata;
                REG_CAM_POS_Y:    r_pos_y   <= pwdata;
                REG_VIEW_DIR_X:   r_dir_x   <= pwdata;
                REG_VIEW_DIR_Y:   r_dir_y   <= pwdata;
                REG_VIEW_PLANE_X: r_plane_x <= pwdata;
                REG_VIEW_PLANE_Y: r_plane_y <= pwdata;
                REG_SCREEN_W:     r_width   <= pwdata[11:0];
                REG_SCREEN_H:     r_height  <= pwdata[11:0];
            endcase
        end
    end

    assign diff  = ($signed({{2{r_pa[63]}}, r_pa}) >>> FRAC_BITS)
                 - ($signed({{2{r_pb[63]}}, r_pb}) >>> FRAC_BITS);
    assign det   = sat32(diff);
    assign trial = {r_rem, (r_cnt == CW'(NB - 1))};
    assign take  = trial >= {1'b0, r_dabs};
    assign qs    = $signed({{(66 - NB){1'b0}}, r_q});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  n_state = ST_IDLE;
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_DET;
            ST_DET:   n_state = ST_DIV;
            ST_DIV:   n_state = (r_cnt == '0) ? ST_SAT : ST_DIV;
            ST_SAT:   n_state = ST_IDLE;
        endcase
        // A new write restarts the sequence on the fresh register values.
        if (wr) begin
            n_state = ST_MUL_A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MUL_A;
        end else begin
            r_state <= n_state;
        end
        unique case (r_state)
            ST_MUL_A: r_pa <= r_plane_x * r_dir_y;
            ST_MUL_B: r_pb <= r_dir_x * r_plane_y;
            ST_DET: begin
                r_det_zero <= (det == 32'sd0);
                r_dneg     <= det[31];
                r_dabs     <= det[31] ? 32'(-det) : det;
                r_rem      <= '0;
                r_q        <= '0;
                r_cnt      <= CW'(NB - 1);
            end
            ST_DIV: begin
                r_rem <= take ? 32'(trial - {1'b0, r_dabs}) : trial[31:0];
                r_q   <= {r_q[NB-2:0], take};
                r_cnt <= r_cnt - 1'b1;
            end
            ST_SAT:  r_inv <= sat32(r_dneg ? -qs : qs);
            ST_IDLE: r_inv <= r_inv;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        o_cam.pos_x    = r_pos_x;
        o_cam.pos_y    = r_pos_y;
        o_cam.dir_x    = r_dir_x;
        o_cam.dir_y    = r_dir_y;
        o_cam.plane_x  = r_plane_x;
        o_cam.plane_y  = r_plane_y;
        o_cam.width    = r_width;
        o_cam.height   = r_height;
        o_cam.inv      = r_inv;
        o_cam.det_zero = r_det_zero;
    end

endmodule

`default_nettype wire

// ===== rtl/core/ssp_front.sv =====
// ----------------------------------------------------------------------------
// Sprite projection front end
// Seven stages: camera-relative offset, rotation into camera space, scaling
// by the inverse determinant and preparation of both divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_front #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_obj_x,
    input  wire logic signed [31:0] i_obj_y,
    input  wire ssp_pkg::t_cam      i_cam,
    output logic                    o_valid,
    output ssp_pkg::t_fr            o_fr
);
    import ssp_pkg::*;

    logic [6:0]         r_v;
    logic signed [32:0] r1_sx, r1_sy;
    logic signed [64:0] r2_pa1, r2_pa2, r2_pb1, r2_pb2;
    logic signed [31:0] r3_a, r3_b;
    logic signed [63:0] r4_la, r4_db;
    logic signed [31:0] r5_lat, r5_dep;
    logic [32:0]        r6_sabs;
    logic [31:0]        r6_dabs;
    logic               r6_sneg, r6_dneg, r6_fault;
    logic signed [31:0] r6_lat, r6_dep;
    t_fr                r7;

    logic signed [32:0] sum;

    assign sum = $signed({r5_dep[31], r5_dep}) + $signed({r5_lat[31], r5_lat});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
        if (i_en) begin
            r1_sx   <= $signed({i_obj_x[31], i_obj_x}) - $signed({i_cam.pos_x[31], i_cam.pos_x});
            r1_sy   <= $signed({i_obj_y[31], i_obj_y}) - $signed({i_cam.pos_y[31], i_cam.pos_y});
            r2_pa1  <= i_cam.dir_y * r1_sx;
            r2_pa2  <= i_cam.dir_x * r1_sy;
            r2_pb1  <= i_cam.plane_x * r1_sy;
            r2_pb2  <= i_cam.plane_y * r1_sx;
            r3_a    <= sat32(($signed({r2_pa1[64], r2_pa1}) >>> FRAC_BITS)
                           - ($signed({r2_pa2[64], r2_pa2}) >>> FRAC_BITS));
            r3_b    <= sat32(($signed({r2_pb1[64], r2_pb1}) >>> FRAC_BITS)
                           - ($signed({r2_pb2[64], r2_pb2}) >>> FRAC_BITS));
            r4_la   <= i_cam.inv * r3_a;
            r4_db   <= i_cam.inv * r3_b;
            r5_lat  <= sat32($signed({{2{r4_la[63]}}, r4_la}) >>> FRAC_BITS);
            r5_dep  <= sat32($signed({{2{r4_db[63]}}, r4_db}) >>> FRAC_BITS);
            r6_sneg <= sum[32];
            r6_sabs <= sum[32] ? 33'(-sum) : sum;
            r6_dneg <= r5_dep[31];
            r6_dabs <= r5_dep[31] ? 32'(-r5_dep) : r5_dep;
            r6_fault <= i_cam.det_zero || (r5_dep == 32'sd0);
            r6_lat  <= r5_lat;
            r6_dep  <= r5_dep;
            r7.ncol  <= DIV_NW'(i_cam.width[11:1]) * DIV_NW'(r6_sabs);
            r7.nsize <= DIV_NW'(i_cam.height) << FRAC_BITS;
            r7.den   <= r6_dabs;
            r7.cneg  <= r6_sneg ^ r6_dneg;
            r7.lat   <= r6_lat;
            r7.dep   <= r6_dep;
            r7.fault <= r6_fault;
        end
    end

    assign o_valid = r_v[6];
    assign o_fr    = r7;

endmodule

`default_nettype wire

// ===== rtl/core/ssp_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with side data and a
// valid bit carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_div #(
    parameter int NW = ssp_pkg::DIV_NW,
    parameter int DW = ssp_pkg::DIV_DW,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);
    logic [NW-1:0] r_vld;
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_num  [NW];
    logic [NW-1:0] r_quo  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];
    logic [DW-1:0] n_rem  [NW];
    logic [NW-1:0] n_num  [NW];
    logic [NW-1:0] n_quo  [NW];
    logic [DW-1:0] p_rem  [NW];
    logic [NW-1:0] p_num  [NW];
    logic [NW-1:0] p_quo  [NW];
    logic [DW-1:0] p_den  [NW];

    // Operands seen by each stage: the first takes the input, the rest the
    // registers of the stage before.
    always_comb begin
        p_rem[0] = '0;
        p_num[0] = i_num;
        p_quo[0] = '0;
        p_den[0] = i_den;
        for (int k = 1; k < NW; k++) begin
            p_rem[k] = r_rem[k-1];
            p_num[k] = r_num[k-1];
            p_quo[k] = r_quo[k-1];
            p_den[k] = r_den[k-1];
        end
    end

    always_comb begin
        logic [DW:0] trial;
        logic        qbit;
        for (int k = 0; k < NW; k++) begin
            trial = {p_rem[k], p_num[k][NW-1]};
            qbit  = trial >= {1'b0, p_den[k]};
            n_rem[k] = qbit ? DW'(trial - {1'b0, p_den[k]}) : trial[DW-1:0];
            n_num[k] = {p_num[k][NW-2:0], 1'b0};
            n_quo[k] = {p_quo[k][NW-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NW-2:0], i_valid};
        end
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= p_den[k];
            end
            for (int k = 1; k < NW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

`default_nettype wire

// ===== rtl/core/ssp_back.sv =====
// ----------------------------------------------------------------------------
// Sprite projection back end
// Signs and saturates the quotients, then clips the draw bounds into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [ssp_pkg::DIV_NW-1:0] i_qcol,
    input  wire logic [ssp_pkg::DIV_NW-1:0] i_qsize,
    input  wire logic                       i_cneg,
    input  wire logic signed [31:0]         i_lat,
    input  wire logic signed [31:0]         i_dep,
    input  wire logic                       i_fault,
    input  wire ssp_pkg::t_cam              i_cam,
    output logic                            o_valid,
    output ssp_pkg::t_res                   o_res
);
    import ssp_pkg::*;

    logic               r1_v, r_v;
    logic signed [15:0] r1_col;
    logic [15:0]        r1_size;
    logic signed [31:0] r1_lat, r1_dep;
    logic               r1_fault;
    t_res               r_res;

    logic signed [DIV_NW:0] cols;
    logic [11:0]            hh;
    logic [14:0]            sz2;
    logic signed [16:0]     top;
    logic [16:0]            bot;
    logic signed [17:0]     lft, rgt;
    t_res                   res;

    assign cols = i_cneg ? -$signed({1'b0, i_qcol}) : $signed({1'b0, i_qcol});
    assign hh   = {1'b0, i_cam.height[11:1]};
    assign sz2  = r1_size[15:1];
    assign top  = $signed({5'd0, hh}) - $signed({2'd0, sz2});
    assign bot  = {5'd0, hh} + {2'd0, sz2};
    assign lft  = $signed({{2{r1_col[15]}}, r1_col}) - $signed({3'd0, sz2});
    assign rgt  = $signed({{2{r1_col[15]}}, r1_col}) + $signed({3'd0, sz2});

    always_comb begin
        res = '0;
        if (!r1_fault) begin
            res.lateral    = r1_lat;
            res.depth      = r1_dep;
            res.screen_col = r1_col;
            res.obj_size   = r1_size;
            res.top_row    = top[16] ? 12'd0 : top[11:0];
            if (bot >= {5'd0, i_cam.height}) begin
                // An empty window pins the bottom row at zero.
                res.bottom_row = (i_cam.height == 12'd0) ? 12'd0 : i_cam.height - 12'd1;
            end else begin
                res.bottom_row = bot[11:0];
            end
            res.left_col   = lft[17] ? 15'd0 : lft[14:0];
            if (rgt >= $signed({6'd0, i_cam.width})) begin
                res.right_col = $signed({4'd0, i_cam.width}) - 16'sd1;
            end else begin
                res.right_col = rgt[15:0];
            end
            res.in_front   = !r1_dep[31] && (r1_dep != 32'sd0);
        end
        res.div_fault = r1_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r_v  <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r_v  <= r1_v;
        end
        if (i_en) begin
            if (cols > (DIV_NW + 1)'(32767)) begin
                r1_col <= 16'sh7fff;
            end else if (cols < -$signed((DIV_NW + 1)'(32768))) begin
                r1_col <= 16'sh8000;
            end else begin
                r1_col <= cols[15:0];
            end
            r1_size  <= (i_qsize > DIV_NW'(65535)) ? 16'hffff : i_qsize[15:0];
            r1_lat   <= i_lat;
            r1_dep   <= i_dep;
            r1_fault <= i_fault;
            r_res    <= res;
        end
    end

    assign o_valid = r_v;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/sprite_screen_projection.sv =====
// ----------------------------------------------------------------------------
// Sprite screen projection
// Moves one sprite world position into camera space and projects it to a
// screen column, square size and clipped draw bounds.
// ----------------------------------------------------------------------------
// The input channel carries one sprite position per transaction on i_valid /
// o_stall; the result channel returns one projection per transaction on
// o_valid / i_stall. A transaction completes at a rising edge with valid high
// and stall low.
// The pipeline takes one sprite in every cycle while o_stall is low. From an
// accepted input to the matching result run seven front stages, 44 stages of
// each per-item divider (one quotient bit per stage) and two back stages.
// The camera determinant and its inverse depend on the registers only. A
// sequencer works them out after reset and after every write to the APB
// port, dividing one bit per cycle; o_stall stays high meanwhile, and then
// falls unless the result channel is stalled.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises, so nothing is lost or repeated.
// A zero determinant or zero depth raises o_div_fault with other fields zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_screen_projection #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ssp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [31:0]         i_obj_x,
    input  wire logic signed [31:0]         i_obj_y,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [31:0]              o_lateral,
    output logic signed [31:0]              o_depth,
    output logic signed [15:0]              o_screen_col,
    output logic [15:0]                     o_obj_size,
    output logic [11:0]                     o_top_row,
    output logic [11:0]                     o_bottom_row,
    output logic [14:0]                     o_left_col,
    output logic signed [15:0]              o_right_col,
    output logic                            o_in_front,
    output logic                            o_div_fault
);
    import ssp_pkg::*;

    t_cam              cam;
    logic              cfg_busy;
    logic              adv;
    logic              fr_valid;
    t_fr               fr;
    logic              dc_valid, ds_valid;
    logic [DIV_NW-1:0] qcol, qsize;
    logic [64:0]       dc_side;
    logic              ds_side;
    t_res              res;

    // The pipeline moves whenever the output register is free or emptying.
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv || cfg_busy;

    ssp_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cam   (cam),
        .o_busy  (cfg_busy)
    );

    ssp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid && !cfg_busy),
        .i_obj_x (i_obj_x),
        .i_obj_y (i_obj_y),
        .i_cam   (cam),
        .o_valid (fr_valid),
        .o_fr    (fr)
    );

    // Column quotient, carrying the camera-space values and the fault flag.
    ssp_div #(.NW(DIV_NW), .DW(DIV_DW), .SW(65)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fr_valid),
        .i_num   (fr.ncol),
        .i_den   (fr.den),
        .i_side  ({fr.lat, fr.dep, fr.fault}),
        .o_valid (dc_valid),
        .o_quo   (qcol),
        .o_side  (dc_side)
    );

    // Size quotient, carrying the sign of the column quotient.
    ssp_div #(.NW(DIV_NW), .DW(DIV_DW), .SW(1)) u_div_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fr_valid),
        .i_num   (fr.nsize),
        .i_den   (fr.den),
        .i_side  (fr.cneg),
        .o_valid (ds_valid),
        .o_quo   (qsize),
        .o_side  (ds_side)
    );

    ssp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (dc_valid),
        .i_qcol  (qcol),
        .i_qsize (qsize),
        .i_cneg  (ds_side),
        .i_lat   (dc_side[64:33]),
        .i_dep   (dc_side[32:1]),
        .i_fault (dc_side[0]),
        .i_cam   (cam),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_lateral    = res.lateral;
    assign o_depth      = res.depth;
    assign o_screen_col = res.screen_col;
    assign o_obj_size   = res.obj_size;
    assign o_top_row    = res.top_row;
    assign o_bottom_row = res.bottom_row;
    assign o_left_col   = res.left_col;
    assign o_right_col  = res.right_col;
    assign o_in_front   = res.in_front;
    assign o_div_fault  = res.div_fault;

    // Both dividers must stay in lock step.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dc_valid == ds_valid)
        else $error("divider lanes out of step");

    // No sprite may enter while the inverse determinant is being formed.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_busy |-> o_stall)
        else $error("input accepted during inverse computation");

    // A faulted result carries zeros in its value fields.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_fault) |-> (o_lateral == 32'sd0 && o_depth == 32'sd0
            && o_obj_size == 16'd0 && !o_in_front))
        else $error("faulted result has non-zero fields");

    // A held output register keeps the pipeline frozen for the next cycle.
    a_hold_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(dc_valid) && $stable(fr_valid))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// ===== dv/sprite_screen_projection_tb.sv =====
// ----------------------------------------------------------------------------
// Sprite screen projection testbench
// Drives sprite positions through the block under a series of camera and
// window settings written over APB. Each accepted transaction is projected by
// a local predictor, and every result transaction is checked field by field
// against the oldest prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_screen_projection_tb;

    import ssp_pkg::*;

    localparam int FRAC      = 16;
    localparam int LATENCY   = 60;     // pipeline depth plus some margin
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_obj_pos;

    // DUT-facing signals; the inputs all have a known value from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_obj_x = '0;
    logic signed [31:0] i_obj_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_res        got;

    // Camera and window registers as the block should hold them.
    logic [31:0] cam_reg [8];

    t_obj_pos    sprite_queue[$];
    t_res        projection_queue[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;     // no idling on either side
    int          send_gap = 0;
    int          stall_left = 0;

    sprite_screen_projection dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_obj_x      (i_obj_x),
        .i_obj_y      (i_obj_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_lateral    (got.lateral),
        .o_depth      (got.depth),
        .o_screen_col (got.screen_col),
        .o_obj_size   (got.obj_size),
        .o_top_row    (got.top_row),
        .o_bottom_row (got.bottom_row),
        .o_left_col   (got.left_col),
        .o_right_col  (got.right_col),
        .o_in_front   (got.in_front),
        .o_div_fault  (got.div_fault)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Projects one sprite with the current camera registers. Every product of
    // two 32-bit Q values is exact in 64 bits and the arithmetic shift floors
    // it; the divisions truncate towards zero, as the hardware's dividers do.
    function automatic t_res project_sprite(logic signed [31:0] ox, logic signed [31:0] oy);
        longint px, py, dx, dy, plx, ply, w, h, sx, sy;
        longint det, inv, a, b, lat, dep, col, size, top, bot, lft, rgt;
        t_res   r;
        r   = '0;
        px  = longint'($signed(cam_reg[REG_CAM_POS_X]));
        py  = longint'($signed(cam_reg[REG_CAM_POS_Y]));
        dx  = longint'($signed(cam_reg[REG_VIEW_DIR_X]));
        dy  = longint'($signed(cam_reg[REG_VIEW_DIR_Y]));
        plx = longint'($signed(cam_reg[REG_VIEW_PLANE_X]));
        ply = longint'($signed(cam_reg[REG_VIEW_PLANE_Y]));
        w   = longint'(cam_reg[REG_SCREEN_W][11:0]);
        h   = longint'(cam_reg[REG_SCREEN_H][11:0]);
        sx  = longint'(ox) - px;
        sy  = longint'(oy) - py;
        det = clamp32(((plx * dy) >>> FRAC) - ((dx * ply) >>> FRAC));
        if (det == 0) begin
            r.div_fault = 1'b1;
            return r;
        end
        inv = clamp32((64'sd1 <<< (2 * FRAC)) / det);
        a   = clamp32(((dy * sx) >>> FRAC) - ((dx * sy) >>> FRAC));
        b   = clamp32(((plx * sy) >>> FRAC) - ((ply * sx) >>> FRAC));
        lat = clamp32((inv * a) >>> FRAC);
        dep = clamp32((inv * b) >>> FRAC);
        if (dep == 0) begin
            r.div_fault = 1'b1;
            return r;
        end
        col = ((w / 2) * (dep + lat)) / dep;
        if (col > 32767) col = 32767;
        if (col < -32768) col = -32768;
        size = (h * (64'sd1 <<< FRAC)) / dep;
        if (size < 0) size = -size;
        if (size > 65535) size = 65535;
        top = h / 2 - size / 2;
        if (top < 0) top = 0;
        bot = h / 2 + size / 2;
        if (bot >= h) bot = h - 1;
        if (bot < 0) bot = 0;
        lft = col - size / 2;
        if (lft < 0) lft = 0;
        rgt = col + size / 2;
        if (rgt >= w) rgt = w - 1;
        r.lateral    = lat[31:0];
        r.depth      = dep[31:0];
        r.screen_col = col[15:0];
        r.obj_size   = size[15:0];
        r.top_row    = top[11:0];
        r.bottom_row = bot[11:0];
        r.left_col   = lft[14:0];
        r.right_col  = rgt[15:0];
        r.in_front   = (dep > 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        mismatch_count++;
        $display("Mismatch on %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, seen, wanted);
    endtask

    task automatic check_field(string what, logic [31:0] seen, logic [31:0] wanted);
        if (seen !== wanted) begin
            report_mismatch(what, seen, wanted);
        end
    endtask

    // Driver: presents queued sprites, holding each payload while stalled.
    always @(posedge i_clk) begin
        t_obj_pos s;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                projection_queue.push_back(project_sprite(i_obj_x, i_obj_y));
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (sprite_queue.size() > 0) begin
                    s = sprite_queue.pop_front();
                    i_valid <= 1'b1;
                    i_obj_x <= s.x;
                    i_obj_y <= s.y;
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 10);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and stalls the block at random.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (projection_queue.size() == 0) begin
                    report_mismatch("unexpected result", got.depth, '0);
                end else begin
                    want = projection_queue.pop_front();
                    check_field("lateral", got.lateral, want.lateral);
                    check_field("depth", got.depth, want.depth);
                    check_field("screen_col", 32'(got.screen_col), 32'(want.screen_col));
                    check_field("obj_size", 32'(got.obj_size), 32'(want.obj_size));
                    check_field("top_row", 32'(got.top_row), 32'(want.top_row));
                    check_field("bottom_row", 32'(got.bottom_row), 32'(want.bottom_row));
                    check_field("left_col", 32'(got.left_col), 32'(want.left_col));
                    check_field("right_col", 32'(got.right_col), 32'(want.right_col));
                    check_field("in_front", 32'(got.in_front), 32'(want.in_front));
                    check_field("div_fault", 32'(got.div_fault), 32'(want.div_fault));
                end
            end
            if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One APB write: a setup cycle, then the access cycle on which the
    // register takes the value (pready is always high).
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cam_reg[idx] = (idx >= REG_SCREEN_W) ? (value & 32'hfff) : value;
    endtask

    task automatic write_camera(logic [31:0] px, logic [31:0] py, logic [31:0] dx,
                                logic [31:0] dy, logic [31:0] plx, logic [31:0] ply,
                                logic [11:0] w, logic [11:0] h);
        write_reg(REG_CAM_POS_X, px);
        write_reg(REG_CAM_POS_Y, py);
        write_reg(REG_VIEW_DIR_X, dx);
        write_reg(REG_VIEW_DIR_Y, dy);
        write_reg(REG_VIEW_PLANE_X, plx);
        write_reg(REG_VIEW_PLANE_Y, ply);
        write_reg(REG_SCREEN_W, 32'(w));
        write_reg(REG_SCREEN_H, 32'(h));
    endtask

    // A plausible camera: a direction within one unit per axis and a plane
    // at right angles to it, about two thirds as long.
    task automatic write_random_camera();
        int dx, dy;
        dx = int'($urandom_range(0, 131072)) - 65536;
        dy = int'($urandom_range(0, 131072)) - 65536;
        write_camera($urandom, $urandom, dx, dy, -(dy * 2) / 3, (dx * 2) / 3,
                     12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
    endtask

    task automatic add_sprite(logic signed [31:0] x, logic signed [31:0] y);
        t_obj_pos s;
        s.x = x;
        s.y = y;
        sprite_queue.push_back(s);
    endtask

    // Mostly sprites within sixteen units of the camera, where sizes and
    // columns stay meaningful; now and then a position anywhere at all.
    task automatic add_random_sprites(int count);
        int span;
        repeat (count) begin
            span = 1 << ($urandom_range(4, 20));
            if ($urandom_range(0, 9) == 0) begin
                add_sprite($urandom, $urandom);
            end else begin
                add_sprite(cam_reg[REG_CAM_POS_X] + int'($urandom_range(0, 2 * span)) - span,
                           cam_reg[REG_CAM_POS_Y] + int'($urandom_range(0, 2 * span)) - span);
            end
        end
    endtask

    // Lets the queued sprites drain, then waits for every result and for the
    // pipeline to settle, so that the registers may be written safely.
    task automatic drain();
        while (sprite_queue.size() > 0 || i_valid || projection_queue.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin
        cam_reg[REG_CAM_POS_X]    = '0;
        cam_reg[REG_CAM_POS_Y]    = '0;
        cam_reg[REG_VIEW_DIR_X]   = RST_DIR_X;
        cam_reg[REG_VIEW_DIR_Y]   = '0;
        cam_reg[REG_VIEW_PLANE_X] = '0;
        cam_reg[REG_VIEW_PLANE_Y] = RST_PLANE_Y;
        cam_reg[REG_SCREEN_W]     = 32'(RST_WIDTH);
        cam_reg[REG_SCREEN_H]     = 32'(RST_HEIGHT);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset camera looks along minus x. A sprite on the camera gives zero
        // depth; sprites ahead, behind, very close and very far follow.
        add_sprite(0, 0);
        add_sprite(32'sh7fffffff, 32'sh7fffffff);
        add_sprite(32'sh80000000, 32'sh80000000);
        add_sprite(32'sh7fffffff, 32'sh80000000);
        add_sprite(32'sh80000000, 32'sh7fffffff);
        add_sprite(-32'sd327680, 0);
        add_sprite(32'sd327680, 0);
        add_sprite(-32'sd65536, 32'sd196608);
        add_sprite(-32'sd1, 0);
        add_sprite(-32'sd65536000, 32'sd65536);
        add_sprite(-32'sd131072, -32'sd131072);
        add_random_sprites(60);
        drain();

        // Parallel direction and plane: the determinant is zero.
        write_camera(32'sd65536, 0, 32'sd65536, 0, 32'sd65536, 0, 12'd320, 12'd200);
        add_sprite(0, 0);
        add_sprite(32'sh7fffffff, 32'sh80000000);
        add_random_sprites(8);
        drain();

        // Register extremes, once at the top and once at the bottom.
        write_camera(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh80000000, 32'sh7fffffff, 12'd4095, 12'd4095);
        add_sprite(32'sh80000000, 32'sh80000000);
        add_random_sprites(40);
        drain();
        write_camera(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh7fffffff, 32'sh80000000, 12'd1, 12'd1);
        add_sprite(32'sh7fffffff, 32'sh7fffffff);
        add_random_sprites(40);
        drain();

        // An empty window: the bottom row pins to zero, the right column to -1.
        write_camera(0, 0, -32'sd65536, 0, 0, 32'sd43254, 12'd0, 12'd0);
        add_sprite(-32'sd327680, 32'sd65536);
        add_random_sprites(20);
        drain();

        // A steady camera scaled small, so that the determinant inverse is big.
        write_camera(0, 0, 32'sd256, 0, 0, 32'sd256, 12'd640, 12'd480);
        add_random_sprites(40);
        drain();

        repeat (7) begin
            write_random_camera();
            add_random_sprites(100);
            drain();
        end

        // Final stretch with neither side idling: back-to-back transactions.
        write_random_camera();
        quiet = 1'b1;
        add_random_sprites(100);
        drain();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
